[rtl/ntia_pkg.sv]
// ----------------------------------------------------------------------------
// ntia_pkg
// Shared types and constants of the nearest track id assigner: the search
// token that runs down the cell chain, the item broadcast and commit groups.
// ----------------------------------------------------------------------------
package ntia_pkg;

    // Table size default and the widest slot index the table may need
    localparam int NUM_TRACKS_DEF = 4;
    localparam int TRK_IDX_W      = 6;

    // Field widths
    localparam int POS_W   = 16;
    localparam int TIME_W  = 32;
    localparam int ID_W    = 32;
    localparam int R2_W    = 32;
    localparam int D2_W    = 34;
    localparam int SLOT_W  = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 2'd1;

    // Register reset values
    localparam logic [15:0]     RADIUS_RESET  = 16'd500;
    localparam logic [R2_W-1:0] R2_RESET      = 32'd250000;
    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd10000;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_INJECT,
        ST_SWEEP,
        ST_COMMIT
    } state_t;

    // Detection held steady for the cells while one item is worked on
    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [TIME_W-1:0]       now;
    } bcast_t;

    // Search token handed from cell to cell
    typedef struct packed {
        logic                 valid;
        logic [ID_W-1:0]      next_id;
        logic                 best_found;
        logic [D2_W-1:0]      best_d2;
        logic [TRK_IDX_W-1:0] best_idx;
        logic [ID_W-1:0]      best_id;
        logic                 free_found;
        logic [TRK_IDX_W-1:0] free_idx;
        logic [ID_W-1:0]      free_id;
    } tok_t;

    // Store the detection into one slot
    typedef struct packed {
        logic                 en;
        logic [TRK_IDX_W-1:0] idx;
    } commit_t;

endpackage

[rtl/nearest_track_id_assigner_top.sv]
// ----------------------------------------------------------------------------
// nearest_track_id_assigner_top
// The accepted detection passes three distance pipeline stages and one
// launch, then the token walks the slot chain, one cell per cycle.
// A new detection is taken only once the token has walked the slot chain;
// a held result stalls only the final commit.
// Reset: all slots untracked, ids 0..NUM_TRACKS-1, radius 500, timeout 10000.
// ----------------------------------------------------------------------------
module nearest_track_id_assigner_top #(
    parameter int NUM_TRACKS = ntia_pkg::NUM_TRACKS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [ntia_pkg::POS_W-1:0]     pos_x,
    input  logic signed [ntia_pkg::POS_W-1:0]     pos_y,
    input  logic signed [ntia_pkg::POS_W-1:0]     pos_z,
    input  logic [ntia_pkg::TIME_W-1:0]           now_ms,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [ntia_pkg::ID_W-1:0]             track_id,
    output logic [ntia_pkg::SLOT_W-1:0]           slot_index,
    output logic signed [ntia_pkg::POS_W-1:0]     out_x,
    output logic signed [ntia_pkg::POS_W-1:0]     out_y,
    output logic signed [ntia_pkg::POS_W-1:0]     out_z,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ntia_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ntia_pkg::CFG_DATA_W-1:0]       cfg_data
);

    logic [ntia_pkg::R2_W-1:0]   r2_reg, r2_next;
    logic [ntia_pkg::TIME_W-1:0] timeout_reg;

    ntia_pkg::bcast_t   bc;
    ntia_pkg::commit_t  commit;
    ntia_pkg::tok_t     tok [NUM_TRACKS+1];
    logic [NUM_TRACKS:0] tok_vld;

    // Configuration: the radius is kept squared
    assign cfg_ready = 1'b1;
    assign r2_next   = {16'b0, cfg_data[15:0]} * {16'b0, cfg_data[15:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r2_reg      <= ntia_pkg::R2_RESET;
            timeout_reg <= ntia_pkg::TIMEOUT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ntia_pkg::REG_MATCH_RADIUS: r2_reg      <= r2_next;
                ntia_pkg::REG_TIMEOUT:      timeout_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // Sequencer
    ntia_ctrl #(
        .NUM_TRACKS (NUM_TRACKS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .now_ms     (now_ms),
        .bc         (bc),
        .tok_inj    (tok[0]),
        .chain_out  (tok[NUM_TRACKS]),
        .commit     (commit),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .track_id   (track_id),
        .slot_index (slot_index),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_z      (out_z)
    );

    // Slot chain
    for (genvar i = 0; i < NUM_TRACKS; i++)
    begin : g_cell
        ntia_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .bc      (bc),
            .timeout (timeout_reg),
            .r2      (r2_reg),
            .tok_in  (tok[i]),
            .commit  (commit),
            .tok_out (tok[i+1])
        );
    end

    for (genvar i = 0; i <= NUM_TRACKS; i++)
    begin : g_vld
        assign tok_vld[i] = tok[i].valid;
    end

    // Only one token is ever in the chain
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vld))
        else $error("more than one token in the slot chain");

endmodule

[rtl/ntia_cell.sv]
// ----------------------------------------------------------------------------
// ntia_cell
// One track slot. Computes its squared distance and idle test in a short
// pipeline, then, when the token passes, frees itself if idle too long and
// offers itself as nearest match or as free slot.
// ----------------------------------------------------------------------------
module ntia_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ntia_pkg::bcast_t                 bc,
    input  logic [ntia_pkg::TIME_W-1:0]      timeout,
    input  logic [ntia_pkg::R2_W-1:0]        r2,
    input  ntia_pkg::tok_t                   tok_in,
    input  ntia_pkg::commit_t                commit,
    output ntia_pkg::tok_t                   tok_out
);

    localparam int IW = ntia_pkg::TRK_IDX_W;
    localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

    // Slot state
    logic [ntia_pkg::ID_W-1:0]          ident_reg;
    logic signed [ntia_pkg::POS_W-1:0]  px_reg, py_reg, pz_reg;
    logic                               active_reg;
    logic [ntia_pkg::TIME_W-1:0]        seen_reg;

    // Distance pipeline
    logic signed [ntia_pkg::POS_W:0]    dx_reg, dy_reg, dz_reg;
    logic signed [ntia_pkg::POS_W:0]    dx_next, dy_next, dz_next;
    logic signed [2*ntia_pkg::POS_W+1:0] px2, py2, pz2;
    logic [31:0]                        sqx_reg, sqy_reg, sqz_reg;
    logic [ntia_pkg::D2_W-1:0]          d2_reg, d2_next;
    logic                               exp_reg, exp_next;
    logic [ntia_pkg::TIME_W-1:0]        idle;

    // Token handling
    logic                               act_eff;
    logic                               hit;
    logic                               take_free;
    logic [ntia_pkg::ID_W-1:0]          id_eff;
    logic                               do_free;
    logic                               do_commit;
    ntia_pkg::tok_t                     tok_next;

    // Differences, squares and sum
    assign dx_next = $signed({px_reg[15], px_reg}) - $signed({bc.x[15], bc.x});
    assign dy_next = $signed({py_reg[15], py_reg}) - $signed({bc.y[15], bc.y});
    assign dz_next = $signed({pz_reg[15], pz_reg}) - $signed({bc.z[15], bc.z});
    assign px2 = dx_reg * dx_reg;
    assign py2 = dy_reg * dy_reg;
    assign pz2 = dz_reg * dz_reg;
    assign d2_next = {2'b00, sqx_reg} + {2'b00, sqy_reg} + {2'b00, sqz_reg};

    // Idle test, modulo 2^32
    assign idle     = bc.now - seen_reg;
    assign exp_next = idle > timeout;

    always_ff @(posedge clk)
    begin
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        dz_reg  <= dz_next;
        sqx_reg <= px2[31:0];
        sqy_reg <= py2[31:0];
        sqz_reg <= pz2[31:0];
        d2_reg  <= d2_next;
        exp_reg <= exp_next;
    end

    // Decide this cell's part when the token passes
    assign act_eff   = active_reg & ~exp_reg;
    assign hit       = tok_in.valid & act_eff & (d2_reg < {2'b00, r2})
                     & (~tok_in.best_found | (d2_reg < tok_in.best_d2));
    assign take_free = tok_in.valid & ~act_eff & ~tok_in.free_found;
    assign id_eff    = exp_reg ? tok_in.next_id : ident_reg;
    assign do_free   = tok_in.valid & exp_reg;
    assign do_commit = commit.en & (commit.idx == MY_IDX);

    always_comb
    begin
        tok_next = tok_in;
        tok_next.next_id = tok_in.next_id + {{(ntia_pkg::ID_W-1){1'b0}}, do_free};
        if (hit)
        begin
            tok_next.best_found = 1'b1;
            tok_next.best_d2    = d2_reg;
            tok_next.best_idx   = MY_IDX;
            tok_next.best_id    = id_eff;
        end
        if (take_free)
        begin
            tok_next.free_found = 1'b1;
            tok_next.free_idx   = MY_IDX;
            tok_next.free_id    = id_eff;
        end
    end

    // Hand the token on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_out <= '0;
        end
        else
        begin
            tok_out <= tok_next;
        end
    end

    // Free on timeout, store on commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ident_reg  <= ntia_pkg::ID_W'(CELL_IDX);
            px_reg     <= '0;
            py_reg     <= '0;
            pz_reg     <= '0;
            active_reg <= 1'b0;
            seen_reg   <= '0;
        end
        else if (do_free)
        begin
            ident_reg  <= tok_in.next_id;
            px_reg     <= '0;
            py_reg     <= '0;
            pz_reg     <= '0;
            active_reg <= 1'b0;
            seen_reg   <= bc.now;
        end
        else if (do_commit)
        begin
            px_reg     <= bc.x;
            py_reg     <= bc.y;
            pz_reg     <= bc.z;
            active_reg <= 1'b1;
            seen_reg   <= bc.now;
        end
    end

endmodule

[rtl/ntia_ctrl.sv]
// ----------------------------------------------------------------------------
// ntia_ctrl
// Sequencer of the assigner: takes a detection, waits out the cells' distance
// pipeline, launches the token, picks the slot and, if one is found, loads the result register.
// ----------------------------------------------------------------------------
module ntia_ctrl #(
    parameter int NUM_TRACKS = ntia_pkg::NUM_TRACKS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [ntia_pkg::POS_W-1:0]   pos_x,
    input  logic signed [ntia_pkg::POS_W-1:0]   pos_y,
    input  logic signed [ntia_pkg::POS_W-1:0]   pos_z,
    input  logic [ntia_pkg::TIME_W-1:0]         now_ms,
    output ntia_pkg::bcast_t                    bc,
    output ntia_pkg::tok_t                      tok_inj,
    input  ntia_pkg::tok_t                      chain_out,
    output ntia_pkg::commit_t                   commit,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ntia_pkg::ID_W-1:0]           track_id,
    output logic [ntia_pkg::SLOT_W-1:0]         slot_index,
    output logic signed [ntia_pkg::POS_W-1:0]   out_x,
    output logic signed [ntia_pkg::POS_W-1:0]   out_y,
    output logic signed [ntia_pkg::POS_W-1:0]   out_z
);

    localparam int IW = ntia_pkg::TRK_IDX_W;
    localparam logic [1:0] CALC_LAST = 2'd2;

    ntia_pkg::state_t state_reg, state_next;
    logic [1:0]       cnt_reg, cnt_next;

    ntia_pkg::bcast_t              bc_reg;
    logic [ntia_pkg::ID_W-1:0]     next_ident_reg;
    logic [IW-1:0]                 hold_idx_reg;
    logic [ntia_pkg::ID_W-1:0]     hold_id_reg;

    logic                                out_valid_reg;
    logic [ntia_pkg::ID_W-1:0]           out_id_reg;
    logic [ntia_pkg::SLOT_W-1:0]         out_idx_reg;
    logic signed [ntia_pkg::POS_W-1:0]   out_x_reg, out_y_reg, out_z_reg;

    logic                          res_found;
    logic [IW-1:0]                 res_idx;
    logic [ntia_pkg::ID_W-1:0]     res_id;
    logic                          out_free;
    logic                          inject;
    logic                          capture;
    logic                          accept;
    logic [IW-1:0]                 commit_idx;
    logic [ntia_pkg::ID_W-1:0]     commit_id;

    // Nearest match first, free slot otherwise
    assign res_found = chain_out.best_found | chain_out.free_found;
    assign res_idx   = chain_out.best_found ? chain_out.best_idx : chain_out.free_idx;
    assign res_id    = chain_out.best_found ? chain_out.best_id  : chain_out.free_id;
    assign out_free  = ~out_valid_reg | out_ready;
    assign accept    = in_valid & in_ready;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ntia_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and controls
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        inject     = 1'b0;
        capture    = 1'b0;
        commit.en  = 1'b0;
        commit_idx = hold_idx_reg;
        commit_id  = hold_id_reg;
        unique case (state_reg)
            ntia_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cnt_next = '0;
                if (in_valid)
                begin
                    state_next = ntia_pkg::ST_CALC;
                end
            end
            ntia_pkg::ST_CALC:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == CALC_LAST)
                begin
                    state_next = ntia_pkg::ST_INJECT;
                end
            end
            ntia_pkg::ST_INJECT:
            begin
                inject     = 1'b1;
                state_next = ntia_pkg::ST_SWEEP;
            end
            ntia_pkg::ST_SWEEP:
            begin
                if (chain_out.valid)
                begin
                    capture = 1'b1;
                    if (!res_found)
                    begin
                        state_next = ntia_pkg::ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        commit.en  = 1'b1;
                        commit_idx = res_idx;
                        commit_id  = res_id;
                        state_next = ntia_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = ntia_pkg::ST_COMMIT;
                    end
                end
            end
            ntia_pkg::ST_COMMIT:
            begin
                if (out_free)
                begin
                    commit.en  = 1'b1;
                    state_next = ntia_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ntia_pkg::ST_IDLE;
            end
        endcase
        commit.idx = commit_idx;
    end

    // Latch the detection
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bc_reg.x   <= pos_x;
            bc_reg.y   <= pos_y;
            bc_reg.z   <= pos_z;
            bc_reg.now <= now_ms;
        end
    end

    // Hold the search result and advance the id counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_ident_reg <= ntia_pkg::ID_W'(NUM_TRACKS);
            hold_idx_reg   <= '0;
            hold_id_reg    <= '0;
        end
        else if (capture)
        begin
            next_ident_reg <= chain_out.next_id;
            hold_idx_reg   <= res_idx;
            hold_id_reg    <= res_id;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit.en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit.en)
        begin
            out_id_reg  <= commit_id;
            out_idx_reg <= commit_idx[ntia_pkg::SLOT_W-1:0];
            out_x_reg   <= bc_reg.x;
            out_y_reg   <= bc_reg.y;
            out_z_reg   <= bc_reg.z;
        end
    end

    // Launch the token into the first cell
    always_comb
    begin
        tok_inj         = '0;
        tok_inj.valid   = inject;
        tok_inj.next_id = next_ident_reg;
    end

    assign bc         = bc_reg;
    assign out_valid  = out_valid_reg;
    assign track_id   = out_id_reg;
    assign slot_index = out_idx_reg;
    assign out_x      = out_x_reg;
    assign out_y      = out_y_reg;
    assign out_z      = out_z_reg;

    // The token leaves the chain only while the sweep waits for it
    a_chain_out_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        chain_out.valid |-> state_reg == ntia_pkg::ST_SWEEP)
        else $error("token left the chain outside the sweep");

    // A result is loaded only when the result register has room
    a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
        commit.en |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten");

    // The id counter moves only when a sweep ends
    a_ident_on_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (next_ident_reg != $past(next_ident_reg)) |-> $past(state_reg == ntia_pkg::ST_SWEEP))
        else $error("id counter moved outside a sweep");

endmodule
